>>> design/norm_clipped_group_sum_defines.svh
// Assertion macros for the grouped-sum block.
`ifndef NORM_CLIPPED_GROUP_SUM_DEFINES_SVH
`define NORM_CLIPPED_GROUP_SUM_DEFINES_SVH
`ifndef SYNTHESIS
`define NCGS_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define NCGS_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define NCGS_ASSERT_IMP(lbl, clk, rst, a, c)
`define NCGS_ASSERT_NXT(lbl, clk, rst, a, c)
`endif
`endif

>>> design/ncgs_pkg.sv
package ncgs_pkg;
  localparam logic [1:0] FUNC_CLIENT = 2'd0;
  localparam logic [1:0] FUNC_MERGE = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;
  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam logic [1:0] REG_LINF = 2'd0;
  localparam logic [1:0] REG_L1 = 2'd1;
  localparam logic [1:0] REG_L2 = 2'd2;

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_CLIENT = 15'b000000000000010,
    S_LREAD  = 15'b000000000000100,
    S_LWAIT  = 15'b000000000001000,
    S_LACC   = 15'b000000000010000,
    S_SQRT   = 15'b000000000100000,
    S_DIV1   = 15'b000000001000000,
    S_DIV2   = 15'b000000010000000,
    S_AREAD  = 15'b000000100000000,
    S_AWAIT  = 15'b000001000000000,
    S_AMUL   = 15'b000010000000000,
    S_AADD   = 15'b000100000000000,
    S_MERGE  = 15'b001000000000000,
    S_READ   = 15'b010000000000000,
    S_CLEAR  = 15'b100000000000000
  } state_t;

  typedef struct packed {
    logic load_in;
    logic clr_step;
    logic client_wr;
    logic norm_start;
    logic list_rd;
    logic sum_rd;
    logic norm_acc;
    logic sqrt_step;
    logic div1_init;
    logic div2_init;
    logic div_step;
    logic div1_done;
    logic div2_done;
    logic mul_step;
    logic add_step;
    logic merge_wr;
    logic read_out;
    logic clr_touch;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic in_last;
    logic list_end;
    logic iter_done;
  } sts_t;
endpackage

>>> design/ncgs_ctrl.sv
`include "norm_clipped_group_sum_defines.svh"
module ncgs_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [1:0] func,
  input  ncgs_pkg::sts_t sts,
  output ncgs_pkg::cmd_t cmd,
  output logic busy
);
  import ncgs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    busy = (state != S_IDLE);
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          unique case (func)
            FUNC_CLIENT: state_next = S_CLIENT;
            FUNC_MERGE: state_next = S_MERGE;
            FUNC_READ: state_next = S_READ;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_CLIENT: begin
        cmd.client_wr = 1'b1;
        if (sts.in_last) begin
          cmd.norm_start = 1'b1;
          state_next = S_LREAD;
        end else state_next = S_IDLE;
      end
      S_LREAD: begin
        if (sts.list_end) state_next = S_SQRT;
        else begin
          cmd.list_rd = 1'b1;
          state_next = S_LWAIT;
        end
      end
      S_LWAIT: begin
        cmd.sum_rd = 1'b1;
        state_next = S_LACC;
      end
      S_LACC: begin
        cmd.norm_acc = 1'b1;
        state_next = S_LREAD;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.iter_done) begin
          cmd.div1_init = 1'b1;
          state_next = S_DIV1;
        end
      end
      S_DIV1: begin
        cmd.div_step = 1'b1;
        if (sts.iter_done) begin
          cmd.div1_done = 1'b1;
          cmd.div2_init = 1'b1;
          state_next = S_DIV2;
        end
      end
      S_DIV2: begin
        cmd.div_step = 1'b1;
        if (sts.iter_done) begin
          cmd.div2_done = 1'b1;
          state_next = S_AREAD;
        end
      end
      S_AREAD: begin
        if (sts.list_end) begin
          cmd.clr_touch = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.list_rd = 1'b1;
          state_next = S_AWAIT;
        end
      end
      S_AWAIT: begin
        cmd.sum_rd = 1'b1;
        state_next = S_AMUL;
      end
      S_AMUL: begin
        cmd.mul_step = 1'b1;
        state_next = S_AADD;
      end
      S_AADD: begin
        cmd.add_step = 1'b1;
        state_next = S_AREAD;
      end
      S_MERGE: begin
        cmd.merge_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_READ: begin
        cmd.read_out = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  `NCGS_ASSERT_NXT(a_start_leaves_idle, clk, rst, start && !busy && func != FUNC_NOP, busy)
  `NCGS_ASSERT_IMP(a_one_hot, clk, rst, 1'b1, $onehot(state))
  `NCGS_ASSERT_IMP(a_out_idle_next, clk, rst, cmd.read_out, state == S_READ)
endmodule

>>> design/ncgs_dp.sv
`include "norm_clipped_group_sum_defines.svh"
module ncgs_dp #(
  parameter int NUM_GROUPS = 1024
) (
  input  logic clk,
  input  logic rst,
  input  ncgs_pkg::cmd_t cmd,
  output ncgs_pkg::sts_t sts,
  input  logic signed [10:0] ordinal,
  input  logic signed [31:0] client_value,
  input  logic signed [63:0] merge_value,
  input  logic last,
  input  logic signed [31:0] linf_bound,
  input  logic [47:0] l1_limit,
  input  logic [47:0] l2_limit,
  output logic [9:0] group_index,
  output logic signed [63:0] group_total
);
  import ncgs_pkg::*;

  localparam int AW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int CW = AW + 1;

  logic [63:0] totals [NUM_GROUPS];
  logic [31:0] sums [NUM_GROUPS];
  logic [AW-1:0] tlist [NUM_GROUPS];
  logic marks [NUM_GROUPS];

  logic [CW-1:0] clr_cnt;
  logic [CW-1:0] tcount;
  logic [CW-1:0] kidx;
  logic in_valid;
  logic in_last;
  logic in_mark;
  logic [AW-1:0] in_idx;
  logic [31:0] in_cval;
  logic [63:0] in_mval;
  logic [9:0] in_low;
  logic [63:0] tot_rd;
  logic [31:0] sum_rd;
  logic [AW-1:0] cur_idx;
  logic [63:0] l1;
  logic [127:0] sq;
  logic [63:0] root;
  logic [127:0] rem_sq;
  logic [65:0] srem;
  logic [6:0] iter;
  logic [127:0] dnum;
  logic [63:0] dden;
  logic [63:0] drem;
  logic [63:0] dq;
  logic [32:0] scale;
  logic use_div1;
  logic use_div2;
  logic [63:0] prod_mag;
  logic prod_neg;
  logic [9:0] out_idx;
  logic [63:0] out_tot;

  logic signed [32:0] clamp_v;
  logic [31:0] mag;
  logic signed [31:0] sv;
  logic [127:0] sqrt_x;
  logic [127:0] sqrt_src;
  logic [67:0] srem_sh;
  logic [67:0] s_trial;
  logic [64:0] rshift;
  logic div_bit;
  logic [63:0] drem_next;
  logic [63:0] dq_next;

  assign sv = signed'(sum_rd);
  always_comb begin
    clamp_v = 33'(sv);
    if (linf_bound > 0) begin
      if (sv < 0) clamp_v = '0;
      else if (sv > linf_bound) clamp_v = 33'(linf_bound);
    end
    mag = clamp_v[32] ? 32'(-clamp_v) : clamp_v[31:0];
  end

  // Root of sq*2^32, one bit per step, with a running remainder.
  assign sqrt_x = {sq[95:0], 32'd0};
  always_comb begin
    sqrt_src = (iter == 7'd0) ? sqrt_x : rem_sq;
    srem_sh = {srem, sqrt_src[127:126]};
    s_trial = {2'd0, root, 2'b01};
  end

  assign rshift = {drem, dnum[127]};
  always_comb begin
    div_bit = rshift[64] || (rshift[63:0] >= dden);
    drem_next = div_bit ? (rshift[63:0] - dden) : rshift[63:0];
    dq_next = {dq[62:0], div_bit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      tcount <= '0;
      in_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_cnt <= clr_cnt + CW'(1);
      if (cmd.load_in) begin
        in_valid <= !ordinal[10] && (32'(ordinal[9:0]) < 32'(NUM_GROUPS));
      end
      if (cmd.client_wr && in_valid && !in_mark
          && tcount < CW'(NUM_GROUPS)) begin
        tcount <= tcount + CW'(1);
      end
      if (cmd.clr_touch) tcount <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_last <= last;
      in_idx <= AW'(ordinal[9:0]);
      in_cval <= client_value;
      in_mval <= merge_value;
      in_low <= ordinal[9:0];
      tot_rd <= totals[AW'(ordinal[9:0])];
      sum_rd <= sums[AW'(ordinal[9:0])];
      in_mark <= marks[AW'(ordinal[9:0])];
    end
    if (cmd.clr_step) begin
      totals[clr_cnt[AW-1:0]] <= '0;
      marks[clr_cnt[AW-1:0]] <= 1'b0;
    end
    if (cmd.client_wr && in_valid) begin
      if (in_mark) sums[in_idx] <= sum_rd + in_cval;
      else if (tcount < CW'(NUM_GROUPS)) begin
        marks[in_idx] <= 1'b1;
        sums[in_idx] <= in_cval;
        tlist[tcount[AW-1:0]] <= in_idx;
      end
    end
    if (cmd.merge_wr && in_valid) totals[in_idx] <= tot_rd + in_mval;
    if (cmd.read_out) begin
      out_idx <= in_low;
      out_tot <= in_valid ? tot_rd : 64'd0;
    end
    if (cmd.norm_start) begin
      l1 <= '0;
      sq <= '0;
      root <= '0;
      srem <= '0;
    end
    if (cmd.norm_start || cmd.div2_done) kidx <= '0;
    else if (cmd.list_rd) kidx <= kidx + CW'(1);
    if (cmd.list_rd) cur_idx <= tlist[kidx[AW-1:0]];
    if (cmd.sum_rd) begin
      sum_rd <= sums[cur_idx];
      tot_rd <= totals[cur_idx];
    end
    if (cmd.norm_acc) begin
      l1 <= l1 + 64'(mag);
      sq <= sq + 128'({32'd0, mag} * {32'd0, mag});
    end
    if (cmd.sqrt_step) begin
      rem_sq <= sqrt_src << 2;
      if (srem_sh >= s_trial) begin
        srem <= 66'(srem_sh - s_trial);
        root <= {root[62:0], 1'b1};
      end else begin
        srem <= srem_sh[65:0];
        root <= {root[62:0], 1'b0};
      end
    end
    if (cmd.norm_start || cmd.div1_init || cmd.div2_init) iter <= '0;
    else if (cmd.sqrt_step || cmd.div_step) iter <= iter + 7'd1;
    if (cmd.div1_init) begin
      dnum <= {64'd0, l1_limit, 16'd0} << 16;
      drem <= '0;
      dq <= '0;
      dden <= l1;
      use_div1 <= (l1_limit != 48'd0) && (64'(l1_limit) < l1);
      scale <= 33'h1_0000_0000;
    end else if (cmd.div2_init) begin
      dnum <= {32'd0, l2_limit, 48'd0};
      drem <= '0;
      dq <= '0;
      dden <= root;
      use_div2 <= (l2_limit != 48'd0) && (root != 64'd0)
                  && ({l2_limit, 16'd0} < root);
    end else if (cmd.div_step) begin
      dnum <= dnum << 1;
      drem <= drem_next;
      dq <= dq_next;
    end
    if (cmd.div1_done && use_div1) scale <= {1'b0, dq_next[31:0]};
    if (cmd.div2_done && use_div2 && 65'(dq_next) < 65'(scale)) scale <= dq_next[32:0];
    if (cmd.mul_step) begin
      prod_mag <= 64'(({32'd0, mag} * {31'd0, scale}) >> 32);
      prod_neg <= clamp_v[32];
    end
    if (cmd.add_step) begin
      totals[cur_idx] <= tot_rd + (prod_neg ? (64'd0 - prod_mag) : prod_mag);
      marks[cur_idx] <= 1'b0;
    end
  end

  always_comb begin
    sts.clr_done = (clr_cnt == CW'(NUM_GROUPS - 1));
    sts.in_last = in_last;
    sts.list_end = (kidx == tcount);
    sts.iter_done = cmd.sqrt_step ? (iter == 7'd63) : (iter == 7'd127);
  end

  assign group_index = out_idx;
  assign group_total = out_tot;

  `NCGS_ASSERT_IMP(a_count_range, clk, rst, 1'b1, tcount <= CW'(NUM_GROUPS))
  `NCGS_ASSERT_NXT(a_touch_clear, clk, rst, cmd.clr_touch, tcount == '0)
  `NCGS_ASSERT_IMP(a_scale_max, clk, rst, cmd.mul_step, scale <= 33'h1_0000_0000)
endmodule

>>> design/norm_clipped_group_sum.sv
// Grouped sum with per-contribution norm clipping.
// A request is taken when start is high and busy is low; func selects a
// client element, a merge element or a read of one group total.
// Client elements accumulate into a local table; an element with last set
// closes the vector, clamps and clips it, and adds it to the totals.
// A read returns group_index and group_total with done high for one cycle,
// registered from the read state; the receiver cannot stall it.
// A merge or read request, or a client element without last, passes
// through a single state before busy drops; no request is taken while
// busy is high. A vector end holds busy while it walks the touched groups
// to form the L1 and L2 norms, takes the root bit by bit, runs the two
// 128-step divisions for the scale, and scales and adds each group.
// After reset the block clears the totals and marks of all NUM_GROUPS
// groups with busy high; configuration writes through the APB port belong
// in idle periods.
// Registers: linf_bound at 0x00, l1_limit at 0x08, l2_limit at 0x10.
// Throughput is set by the sequential controller and one-port tables.
module norm_clipped_group_sum #(
  parameter int NUM_GROUPS = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] func,
  input  logic signed [10:0] ordinal,
  input  logic signed [31:0] client_value,
  input  logic signed [63:0] merge_value,
  input  logic last,
  output logic done,
  output logic [9:0] group_index,
  output logic signed [63:0] group_total,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [4:0] paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic pready
);
  import ncgs_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic signed [31:0] linf_bound;
  logic [47:0] l1_limit;
  logic [47:0] l2_limit;
  logic [1:0] reg_sel;

  assign pready = 1'b1;
  assign reg_sel = paddr[4:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      linf_bound <= '0;
      l1_limit <= '0;
      l2_limit <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.read_out;
      if (psel && penable && pwrite) begin
        unique case (reg_sel)
          REG_LINF: linf_bound <= pwdata[31:0];
          REG_L1: l1_limit <= pwdata[47:0];
          REG_L2: l2_limit <= pwdata[47:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LINF: prdata = 64'(unsigned'(linf_bound));
      REG_L1: prdata = 64'(l1_limit);
      REG_L2: prdata = 64'(l2_limit);
      default: prdata = '0;
    endcase
  end

  ncgs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .func(func),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  ncgs_dp #(.NUM_GROUPS(NUM_GROUPS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .ordinal(ordinal), .client_value(client_value), .merge_value(merge_value),
    .last(last), .linf_bound(linf_bound), .l1_limit(l1_limit),
    .l2_limit(l2_limit), .group_index(group_index), .group_total(group_total)
  );
endmodule
